/* rtl/core/catan_pkg.sv */
// Shared types and constants for the CORDIC arctangent pipeline.
// Holds the atan(2^-i) table and the rounding helper; no dependencies.
package catan_pkg;

  // Internal x/y width: |(x, y)| * CORDIC gain stays below 2^17.
  localparam int XY_WIDTH    = 18;
  // Internal angle width: quarter turn plus all table angles stays below 2^30.
  localparam int ANGLE_WIDTH = 32;
  localparam int TABLE_BITS  = 28;
  localparam int TABLE_DEPTH = 28;
  localparam int CONST_WIDTH = 29;

  // round(pi/2 * 2^28)
  localparam logic [CONST_WIDTH-1:0] QUARTER_28 = 29'd421657428;

  // round(atan(2^-i) * 2^28)
  localparam logic [CONST_WIDTH-1:0] ATAN_TABLE [TABLE_DEPTH] = '{
    29'd210828714, 29'd124459457, 29'd65760959, 29'd33381290,
    29'd16755422,  29'd8385879,   29'd4193963,  29'd2097109,
    29'd1048571,   29'd524287,    29'd262144,   29'd131072,
    29'd65536,     29'd32768,     29'd16384,    29'd8192,
    29'd4096,      29'd2048,      29'd1024,     29'd512,
    29'd256,       29'd128,       29'd64,       29'd32,
    29'd16,        29'd8,         29'd4,        29'd2
  };

  // One micro-rotation stage's payload.
  typedef struct packed {
    logic signed [XY_WIDTH-1:0]    x;
    logic signed [XY_WIDTH-1:0]    y;
    logic signed [ANGLE_WIDTH-1:0] theta;
  } catan_vec_t;

  // Round a 2^28-scaled constant down to frac_bits fraction bits.
  function automatic logic [CONST_WIDTH-1:0] catan_rescale(
    input logic [CONST_WIDTH-1:0] value,
    input int                     frac_bits
  );
    int                     shift;
    logic [CONST_WIDTH:0]   sum;
    shift = TABLE_BITS - frac_bits;
    if (shift <= 0) begin
      return value;
    end
    sum = {1'b0, value} + ((CONST_WIDTH+1)'(1) << (shift - 1));
    return CONST_WIDTH'(sum >> shift);
  endfunction

endpackage

/* rtl/core/catan_cell.sv */
// One CORDIC vectoring micro-rotation as a registered pipeline cell.
// Depends on catan_pkg for the stage payload type.
module catan_cell #(
  parameter int                                    SHIFT = 0,
  parameter logic [catan_pkg::CONST_WIDTH-1:0]     STEP  = '0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  catan_pkg::catan_vec_t up_data,
  output logic                  down_valid,
  input  logic                  down_ready,
  output catan_pkg::catan_vec_t down_data
);

  localparam logic signed [catan_pkg::ANGLE_WIDTH-1:0] STEP_EXT =
    $signed({{(catan_pkg::ANGLE_WIDTH - catan_pkg::CONST_WIDTH){1'b0}}, STEP});

  logic                  valid;
  catan_pkg::catan_vec_t data;
  catan_pkg::catan_vec_t data_next;
  logic signed [catan_pkg::XY_WIDTH-1:0] dx;
  logic signed [catan_pkg::XY_WIDTH-1:0] dy;
  logic                                  differ;

  // Rotate toward the y axis; shifts use the values before the step
  always_comb begin
    dx     = up_data.x >>> SHIFT;
    dy     = up_data.y >>> SHIFT;
    differ = up_data.x[catan_pkg::XY_WIDTH-1] ^ up_data.y[catan_pkg::XY_WIDTH-1];
    if (differ) begin
      data_next.x     = up_data.x + dy;
      data_next.y     = up_data.y - dx;
      data_next.theta = up_data.theta + STEP_EXT;
    end else begin
      data_next.x     = up_data.x - dy;
      data_next.y     = up_data.y + dx;
      data_next.theta = up_data.theta - STEP_EXT;
    end
  end

  // Stage can take an item when empty or when its item moves on
  assign up_ready = !valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign down_valid = valid;
  assign down_data  = data;

endmodule

/* rtl/core/cordic_arctangent.sv */
// CORDIC arctangent (vectoring mode) top level: start stage plus a row of cells.
// Depends on catan_pkg and catan_cell.
//
// Usage:
//   Input channel item_valid/item_ready carries x_value and y_value (signed 16 bit).
//   Output channel result_valid/result_ready carries angle, atan(y/x) as a signed
//   30-bit value with FRACTION_BITS fraction bits (2Q28 by default). Not atan2.
//   Stages: ITERATIONS + 1 registers, the start register followed by one
//   registered cell per micro-rotation; each item passes through them in order.
//   Throughput: one item per clock while the receiver does not stall.
//   Each stage holds its item while the one after it is full and stalled; a
//   stage with a bubble keeps accepting, so bubbles close up under a stall.
//   With result_ready high, item_ready is high every cycle.
//   Reset (rst, synchronous) empties every stage; no result is pending after it.
//   Results leave in the order items were accepted, one result per item.
module cordic_arctangent #(
  parameter int ITERATIONS    = 16,
  parameter int FRACTION_BITS = 28
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [15:0] x_value,
  input  logic [15:0] y_value,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [29:0] angle
);

  localparam logic [catan_pkg::CONST_WIDTH-1:0] QUARTER =
    catan_pkg::catan_rescale(catan_pkg::QUARTER_28, FRACTION_BITS);
  localparam logic signed [catan_pkg::ANGLE_WIDTH-1:0] QUARTER_EXT =
    $signed({{(catan_pkg::ANGLE_WIDTH - catan_pkg::CONST_WIDTH){1'b0}}, QUARTER});

  logic                  stage_valid [ITERATIONS+1];
  logic                  stage_ready [ITERATIONS+1];
  catan_pkg::catan_vec_t stage_data  [ITERATIONS+1];

  logic                  start_valid;
  catan_pkg::catan_vec_t start_data;
  catan_pkg::catan_vec_t start_next;

  // Start angle: +quarter turn when x and y signs agree, else -quarter turn
  always_comb begin
    start_next.x     = catan_pkg::XY_WIDTH'($signed(x_value));
    start_next.y     = catan_pkg::XY_WIDTH'($signed(y_value));
    start_next.theta = (x_value[15] == y_value[15]) ? QUARTER_EXT : -QUARTER_EXT;
  end

  assign item_ready = !start_valid || stage_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_valid <= 1'b0;
    end else if (item_ready) begin
      start_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      start_data <= start_next;
    end
  end

  assign stage_valid[0] = start_valid;
  assign stage_data[0]  = start_data;

  // One cell per micro-rotation
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    catan_cell #(
      .SHIFT (i),
      .STEP  (catan_pkg::catan_rescale(catan_pkg::ATAN_TABLE[i], FRACTION_BITS))
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (stage_valid[i]),
      .up_ready   (stage_ready[i]),
      .up_data    (stage_data[i]),
      .down_valid (stage_valid[i+1]),
      .down_ready (stage_ready[i+1]),
      .down_data  (stage_data[i+1])
    );
  end

  // Last cell register is the output register
  assign stage_ready[ITERATIONS] = result_ready;
  assign result_valid            = stage_valid[ITERATIONS];
  assign angle                   = stage_data[ITERATIONS].theta[29:0];

  // No result may be pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result pending after reset");

  // A free receiver keeps the whole pipeline moving
  a_flow: assert property (@(posedge clk) disable iff (rst)
    result_ready |-> item_ready)
    else $error("input stalled while receiver ready");

  // An empty start stage always takes an item
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    !start_valid |-> item_ready)
    else $error("empty start stage refused an item");

  // A stalled result keeps its angle
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(angle)))
    else $error("stalled result changed");

endmodule
